### sv/gwps_pkg.sv
// Types, widths and constants of the Gaussian wave packet sampler.
// Holds the CORDIC arctangent table in units of 2^-32 turn.
// No dependencies.
`default_nettype none

package gwps_pkg;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned SPAN_W    = 15;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PROD_W = IDX_W + SPAN_W;
  localparam int unsigned X_W    = PROD_W + 2;
  localparam int unsigned D_W    = X_W + 1;
  localparam int unsigned MAG_W  = 23;
  localparam int unsigned Y_W    = 2 * MAG_W - 21;
  localparam int unsigned Y2_W   = 2 * Y_W - 32;
  localparam int unsigned Y3_W   = Y2_W + Y_W - 32;
  localparam int unsigned A_W    = 33;
  localparam int unsigned P_W    = 32;
  localparam int unsigned ENV_W  = 16;
  localparam int unsigned PH_W   = 32;
  localparam int unsigned PHP_W  = 20;
  localparam int unsigned CORD_W = 33;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned RP_W   = CORD_W + ENV_W + 1;

  localparam int unsigned ENV_SQUARINGS = 12;
  localparam int unsigned ATAN_ENTRIES  = 24;

  localparam logic [15:0] DIV6_RECIP = 16'd43691;
  localparam int unsigned DIV6_SHIFT = 18;
  localparam int unsigned Q6_W       = Y3_W + 16 - DIV6_SHIFT;

  localparam logic [ENV_W-1:0] ENV_ONE = 16'd32768;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 33'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT    = 3'd0,
    REG_START_POSITION  = 3'd1,
    REG_SPAN_LENGTH     = 3'd2,
    REG_TURNS_PER_UNIT  = 3'd3,
    REG_CENTER_POSITION = 3'd4,
    REG_INVERSE_WIDTH   = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic logic signed [15:0] sat16(input logic signed [RP_W-10:0] v);
    logic signed [15:0] r;
    if (v > $signed((RP_W-9)'(32767))) begin
      r = 16'sd32767;
    end else if (v < -$signed((RP_W-9)'(32768))) begin
      r = -16'sd32768;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/gaussian_wave_packet_sampler_core.sv
// Gaussian wave packet sampler: one complex Q1.15 sample per sample index.
// Pipeline: a product stage, a 27-stage restoring divider, eight position
// and envelope stages, twelve squaring stages, the CORDIC stages and two
// output stages. One request is accepted every cycle unless the output stalls.
// A stall at the output holds the whole pipeline. Reset loads the register
// defaults and clears every valid bit. Depends on gwps_pkg.
`default_nettype none

module gaussian_wave_packet_sampler_core #(
  parameter int unsigned MAX_SAMPLES   = 4096,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [gwps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gwps_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gwps_pkg::IDX_W-1:0]           in_sample_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   out_real_part,
  output logic signed [15:0]                   out_imag_part
);
  import gwps_pkg::*;

  localparam int unsigned LAT = 1 + PROD_W + 8 + ENV_SQUARINGS + 1 + CORDIC_STAGES + 2;
  localparam int unsigned ENV_STG = 1 + PROD_W + 8 + ENV_SQUARINGS;
  localparam int unsigned CRD_STG = ENV_STG + CORDIC_STAGES;

  logic [CNT_W-1:0]         sample_count_r;
  logic signed [POS_W-1:0]  start_position_r;
  logic [SPAN_W-1:0]        span_length_r;
  logic signed [POS_W-1:0]  turns_per_unit_r;
  logic signed [POS_W-1:0]  center_position_r;
  logic [POS_W-1:0]         inverse_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r    <= 13'd50;
      start_position_r  <= -16'sd4096;
      span_length_r     <= 15'd8192;
      turns_per_unit_r  <= '0;
      center_position_r <= '0;
      inverse_width_r   <= 16'd256;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT:    sample_count_r    <= cfg_data[CNT_W-1:0];
        REG_START_POSITION:  start_position_r  <= $signed(cfg_data);
        REG_SPAN_LENGTH:     span_length_r     <= cfg_data[SPAN_W-1:0];
        REG_TURNS_PER_UNIT:  turns_per_unit_r  <= $signed(cfg_data);
        REG_CENTER_POSITION: center_position_r <= $signed(cfg_data);
        REG_INVERSE_WIDTH:   inverse_width_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic [CNT_W-1:0] div_d;
  always_comb begin
    if (sample_count_r == '0) begin
      div_d = CNT_W'(1);
    end else if (32'(sample_count_r) > MAX_SAMPLES) begin
      div_d = CNT_W'(MAX_SAMPLES);
    end else begin
      div_d = sample_count_r;
    end
  end

  logic [PROD_W-1:0] kspan_r;
  always_ff @(posedge clk) begin
    if (en) begin
      kspan_r <= PROD_W'(in_sample_index) * PROD_W'(span_length_r);
    end
  end

  logic [CNT_W-1:0]  rem_r [PROD_W];
  logic [PROD_W-1:0] wq_r  [PROD_W];

  for (genvar g = 0; g < PROD_W; g++) begin : g_div
    logic [CNT_W-1:0]  rem_in;
    logic [PROD_W-1:0] w_in;
    logic [CNT_W:0]    trial;
    logic              ge;
    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign w_in   = kspan_r;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign w_in   = wq_r[g-1];
    end
    assign trial = {rem_in, w_in[PROD_W-1]};
    assign ge    = trial >= {1'b0, div_d};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? CNT_W'(trial - {1'b0, div_d}) : CNT_W'(trial);
        wq_r[g]  <= {w_in[PROD_W-2:0], ge};
      end
    end
  end

  logic signed [X_W-1:0] x_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= $signed({2'b00, wq_r[PROD_W-1]}) + X_W'(start_position_r);
    end
  end

  logic [PHP_W-1:0]      tx;
  logic [PH_W-1:0]       ph_a_r;
  logic signed [D_W-1:0] d_a_r;
  assign tx = x_r[PHP_W-1:0] * PHP_W'(turns_per_unit_r);
  always_ff @(posedge clk) begin
    if (en) begin
      ph_a_r <= {tx, 12'd0};
      d_a_r  <= D_W'(x_r) - D_W'(center_position_r);
    end
  end

  logic [D_W-2:0]       dabs;
  logic [D_W+14:0]      magw;
  logic [MAG_W-1:0]     mag_b_r;
  logic                 far_b_r;
  logic [PH_W-1:0]      ph_b_r;
  assign dabs = d_a_r[D_W-1] ? (D_W-1)'(-d_a_r) : (D_W-1)'(d_a_r);
  assign magw = dabs * inverse_width_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_b_r <= magw[MAG_W-1:0];
      far_b_r <= |magw[D_W+14:MAG_W];
      ph_b_r  <= ph_a_r;
    end
  end

  logic [2*MAG_W-1:0] msq;
  logic [Y_W-1:0]     y_c_r;
  logic               far_c_r;
  logic [PH_W-1:0]    ph_c_r;
  assign msq = mag_b_r * mag_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      y_c_r   <= msq[2*MAG_W-1:21];
      far_c_r <= far_b_r;
      ph_c_r  <= ph_b_r;
    end
  end

  logic [2*Y_W-1:0] ysq;
  logic [Y_W-1:0]   y_d_r;
  logic [Y2_W-1:0]  y2_d_r;
  logic             far_d_r;
  logic [PH_W-1:0]  ph_d_r;
  assign ysq = y_c_r * y_c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      y_d_r   <= y_c_r;
      y2_d_r  <= ysq[2*Y_W-1:32];
      far_d_r <= far_c_r;
      ph_d_r  <= ph_c_r;
    end
  end

  logic [Y2_W+Y_W-1:0] y3p;
  logic [Y3_W-1:0]     y3_e_r;
  logic [A_W-1:0]      a_e_r;
  logic                far_e_r;
  logic [PH_W-1:0]     ph_e_r;
  assign y3p = y2_d_r * y_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      y3_e_r  <= y3p[Y2_W+Y_W-1:32];
      a_e_r   <= 33'h1_0000_0000 - A_W'(y_d_r) + A_W'(y2_d_r >> 1);
      far_e_r <= far_d_r;
      ph_e_r  <= ph_d_r;
    end
  end

  logic [Y3_W+15:0] q6p;
  logic [Q6_W-1:0]  q6_f_r;
  logic [A_W-1:0]   a_f_r;
  logic             far_f_r;
  logic [PH_W-1:0]  ph_f_r;
  assign q6p = y3_e_r * DIV6_RECIP;
  always_ff @(posedge clk) begin
    if (en) begin
      q6_f_r  <= q6p[Y3_W+15:DIV6_SHIFT];
      a_f_r   <= a_e_r;
      far_f_r <= far_e_r;
      ph_f_r  <= ph_e_r;
    end
  end

  logic [A_W-1:0]  pfull;
  logic [P_W-1:0]  p_g_r;
  logic            far_g_r;
  logic [PH_W-1:0] ph_g_r;
  assign pfull = a_f_r - A_W'(q6_f_r);
  always_ff @(posedge clk) begin
    if (en) begin
      p_g_r   <= pfull[A_W-1:1];
      far_g_r <= far_f_r;
      ph_g_r  <= ph_f_r;
    end
  end

  logic [P_W-1:0]  p_sq_r   [ENV_SQUARINGS];
  logic            far_sq_r [ENV_SQUARINGS];
  logic [PH_W-1:0] ph_sq_r  [ENV_SQUARINGS];

  for (genvar s = 0; s < ENV_SQUARINGS; s++) begin : g_sq
    logic [P_W-1:0]   p_in;
    logic             far_in;
    logic [PH_W-1:0]  ph_in;
    logic [2*P_W-1:0] psq;
    if (s == 0) begin : g_first
      assign p_in   = p_g_r;
      assign far_in = far_g_r;
      assign ph_in  = ph_g_r;
    end else begin : g_next
      assign p_in   = p_sq_r[s-1];
      assign far_in = far_sq_r[s-1];
      assign ph_in  = ph_sq_r[s-1];
    end
    assign psq = p_in * p_in;
    always_ff @(posedge clk) begin
      if (en) begin
        p_sq_r[s]   <= psq[2*P_W-2:P_W-1];
        far_sq_r[s] <= far_in;
        ph_sq_r[s]  <= ph_in;
      end
    end
  end

  logic [A_W-1:0]  env_sum;
  logic [PH_W-1:0] ph_fold;
  logic            fold;
  logic [ENV_W-1:0] env_r;
  assign env_sum = A_W'(p_sq_r[ENV_SQUARINGS-1]) + A_W'(32768);
  assign fold    = ph_sq_r[ENV_SQUARINGS-1][PH_W-1] ^ ph_sq_r[ENV_SQUARINGS-1][PH_W-2];
  assign ph_fold = ph_sq_r[ENV_SQUARINGS-1] ^ {fold, {(PH_W-1){1'b0}}};

  logic signed [CORD_W-1:0] cx_r  [CORDIC_STAGES+1];
  logic signed [CORD_W-1:0] cy_r  [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]    z_r   [CORDIC_STAGES+1];
  logic [ENV_W-1:0]         ce_r  [CORDIC_STAGES+1];
  logic                     neg_r [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      env_r    <= far_sq_r[ENV_SQUARINGS-1] ? '0 : env_sum[ENV_W+15:16];
      cx_r[0]  <= CORDIC_X0;
      cy_r[0]  <= '0;
      z_r[0]   <= Z_W'($signed(ph_fold));
      ce_r[0]  <= far_sq_r[ENV_SQUARINGS-1] ? '0 : env_sum[ENV_W+15:16];
      neg_r[0] <= fold;
    end
  end

  for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [Z_W-1:0]    at;
    assign dx = cy_r[c] >>> c;
    assign dy = cx_r[c] >>> c;
    assign at = $signed({2'b00, ATAN_TURNS[c]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[c][Z_W-1]) begin
          cx_r[c+1] <= cx_r[c] - dx;
          cy_r[c+1] <= cy_r[c] + dy;
          z_r[c+1]  <= z_r[c] - at;
        end else begin
          cx_r[c+1] <= cx_r[c] + dx;
          cy_r[c+1] <= cy_r[c] - dy;
          z_r[c+1]  <= z_r[c] + at;
        end
        ce_r[c+1]  <= ce_r[c];
        neg_r[c+1] <= neg_r[c];
      end
    end
  end

  logic signed [RP_W-1:0] pre_r;
  logic signed [RP_W-1:0] pim_r;
  logic                   pneg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pre_r  <= RP_W'(cx_r[CORDIC_STAGES] * $signed({1'b0, ce_r[CORDIC_STAGES]}));
      pim_r  <= RP_W'(cy_r[CORDIC_STAGES] * $signed({1'b0, ce_r[CORDIC_STAGES]}));
      pneg_r <= neg_r[CORDIC_STAGES];
    end
  end

  logic signed [RP_W-1:0] vre;
  logic signed [RP_W-1:0] vim;
  logic signed [RP_W-1:0] rre;
  logic signed [RP_W-1:0] rim;
  assign vre = pneg_r ? -pre_r : pre_r;
  assign vim = pneg_r ? -pim_r : pim_r;
  assign rre = (vre + $signed(RP_W'(1) <<< 29)) >>> 30;
  assign rim = (vim + $signed(RP_W'(1) <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      out_real_part <= sat16(rre[RP_W-10:0]);
      out_imag_part <= sat16(rim[RP_W-10:0]);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ENV_STG] |-> (env_r <= ENV_ONE))
    else $error("envelope above one");

  a_cordic_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CRD_STG] |-> (cx_r[CORDIC_STAGES][CORD_W-1] == cx_r[CORDIC_STAGES][CORD_W-2]))
    else $error("CORDIC x out of range");

endmodule

`default_nettype wire
